// File: rtl/sbt_pkg.sv
`timescale 1ns / 1ps
package sbt_pkg;

  // Line counter width; the result field always carries 24 bits of it.
  localparam int LINE_BITS = 24;
  localparam int LINE_OUT_W = 24;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic [2:0] KIND_CONTENT = 3'd0;
  localparam logic [2:0] KIND_END     = 3'd1;
  localparam logic [2:0] KIND_OPEN    = 3'd2;
  localparam logic [2:0] KIND_CLOSE   = 3'd3;
  localparam logic [2:0] KIND_EOF     = 3'd4;
  localparam logic [2:0] KIND_INVALID = 3'd5;

  // Token classes
  localparam logic [2:0] CLS_NONE    = 3'd0;
  localparam logic [2:0] CLS_SYMBOL  = 3'd1;
  localparam logic [2:0] CLS_STRING  = 3'd2;
  localparam logic [2:0] CLS_NUMBER  = 3'd3;
  localparam logic [2:0] CLS_KEYWORD = 3'd4;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_COMMENT = 6'b000010,
    MODE_STRING  = 6'b000100,
    MODE_NUMBER  = 6'b001000,
    MODE_KEYWORD = 6'b010000,
    MODE_SYMBOL  = 6'b100000
  } lex_mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] cls;
    logic [7:0] ch;
  } res_t;

  // All results caused by one source byte, as one queue entry.
  typedef struct packed {
    logic                  two;
    res_t                  first;
    res_t                  second;
    logic [LINE_OUT_W-1:0] line;
  } tok_run_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/sbt_in_if.sv
`timescale 1ns / 1ps
interface sbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

// File: rtl/sbt_out_if.sv
`timescale 1ns / 1ps
interface sbt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  token_class;
  logic [7:0]  char_out;
  logic [23:0] line_number;
  logic        last_of_run;

  modport source (output valid, output kind, output token_class, output char_out,
                  output line_number, output last_of_run, input ready);
  modport sink (input valid, input kind, input token_class, input char_out,
                input line_number, input last_of_run, output ready);
endinterface

// File: rtl/sexpr_byte_tokenizer_core.sv
`timescale 1ns / 1ps
// Path: each accepted byte's results are written as one queue entry; its first
// result beat is then loaded into the output register, which drives the port.
// Throughput: one byte per cycle while the queue has room and each byte has
// at most one result; two results need two output beats, the port moving one
// beat per cycle while ready is high; a 4-entry queue absorbs the difference.
// Reset (rst_n low, synchronous): mode idle, line 1, queue and output empty.
module sexpr_byte_tokenizer_core (
  input  logic      clk,
  input  logic      rst_n,
  sbt_in_if.sink    in_ch,
  sbt_out_if.source out_ch
);

  // Front: lex each accepted byte in a single step and build one queue entry
  // holding every result the byte causes, stamped with the current line.
  // Back: drain entries one result beat at a time through an output register.

  sbt_pkg::tok_run_t push_data;
  sbt_pkg::tok_run_t head;
  sbt_pkg::q_ctl_t   q_ctl;
  sbt_pkg::q_stat_t  q_stat;
  logic              accept;
  logic              push;
  logic              pop;

  // Take a byte whenever the queue has room; the front never stalls otherwise.
  assign in_ch.ready = !q_stat.full;
  assign accept = in_ch.valid && in_ch.ready;

  sbt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .byte_in   (in_ch.source_byte),
    .push      (push),
    .push_data (push_data)
  );

  assign q_ctl = '{push: push, pop: pop};

  sbt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (q_ctl),
    .wr_data (push_data),
    .head    (head),
    .stat    (q_stat)
  );

  // Mark the final beat of each entry as last_of_run.
  sbt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_stat.empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/sbt_front.sv
`timescale 1ns / 1ps
module sbt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        byte_in,
  output logic              push,
  output sbt_pkg::tok_run_t push_data
);

  typedef struct packed {
    logic              emit;
    sbt_pkg::res_t     res;
    sbt_pkg::lex_mode_t mode;
    logic              set_quote;
    logic              quote_single;
    logic              line_inc;
  } idle_out_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
  endfunction

  // Lex one byte from idle mode.
  function automatic idle_out_t idle_lex(input logic [7:0] b);
    idle_out_t o;
    o = '0;
    o.mode = sbt_pkg::MODE_IDLE;
    o.res.ch = b;
    o.res.cls = sbt_pkg::CLS_NONE;
    case (b)
      sbt_pkg::CH_NUL: begin
        o.emit = 1'b1;
        o.res.kind = sbt_pkg::KIND_EOF;
      end
      sbt_pkg::CH_LF, sbt_pkg::CH_CR: o.line_inc = 1'b1;
      sbt_pkg::CH_SPACE, sbt_pkg::CH_TAB, sbt_pkg::CH_FF, sbt_pkg::CH_VT: o.emit = 1'b0;
      sbt_pkg::CH_SEMI: o.mode = sbt_pkg::MODE_COMMENT;
      sbt_pkg::CH_LPAREN: begin
        o.emit = 1'b1;
        o.res.kind = sbt_pkg::KIND_OPEN;
      end
      sbt_pkg::CH_RPAREN: begin
        o.emit = 1'b1;
        o.res.kind = sbt_pkg::KIND_CLOSE;
      end
      sbt_pkg::CH_DQUOTE, sbt_pkg::CH_SQUOTE: begin
        o.mode = sbt_pkg::MODE_STRING;
        o.set_quote = 1'b1;
        o.quote_single = (b == sbt_pkg::CH_SQUOTE);
      end
      sbt_pkg::CH_COLON: o.mode = sbt_pkg::MODE_KEYWORD;
      default: begin
        o.emit = 1'b1;
        if (is_digit(b)) begin
          o.mode = sbt_pkg::MODE_NUMBER;
          o.res.kind = sbt_pkg::KIND_CONTENT;
          o.res.cls = sbt_pkg::CLS_NUMBER;
        end else if (is_alpha(b)) begin
          o.mode = sbt_pkg::MODE_SYMBOL;
          o.res.kind = sbt_pkg::KIND_CONTENT;
          o.res.cls = sbt_pkg::CLS_SYMBOL;
        end else begin
          o.res.kind = sbt_pkg::KIND_INVALID;
        end
      end
    endcase
    return o;
  endfunction

  sbt_pkg::lex_mode_t             mode_r, mode_nxt;
  logic                           quote_single_r, quote_single_nxt;
  logic [sbt_pkg::LINE_BITS-1:0]  line_r, line_nxt;
  idle_out_t                      idle;
  logic                           emit;
  logic                           two;
  sbt_pkg::res_t                  first, second;
  logic [2:0]                     run_cls;
  logic                           more;
  logic [7:0]                     quote_ch;

  always_comb begin
    idle = idle_lex(byte_in);
    mode_nxt = mode_r;
    quote_single_nxt = quote_single_r;
    line_nxt = line_r;
    emit = 1'b0;
    two = 1'b0;
    first = '0;
    second = '0;
    run_cls = sbt_pkg::CLS_SYMBOL;
    more = 1'b0;
    quote_ch = quote_single_r ? sbt_pkg::CH_SQUOTE : sbt_pkg::CH_DQUOTE;

    unique case (mode_r)
      sbt_pkg::MODE_COMMENT: begin
        if ((byte_in == sbt_pkg::CH_NUL) || (byte_in == sbt_pkg::CH_LF) ||
            (byte_in == sbt_pkg::CH_CR)) begin
          emit = idle.emit;
          first = idle.res;
          mode_nxt = idle.mode;
          if (idle.line_inc && (line_r != '1)) line_nxt = line_r + 1'b1;
        end
      end
      sbt_pkg::MODE_STRING: begin
        emit = 1'b1;
        if (byte_in == quote_ch) begin
          first = '{kind: sbt_pkg::KIND_END, cls: sbt_pkg::CLS_STRING, ch: byte_in};
          mode_nxt = sbt_pkg::MODE_IDLE;
        end else if (byte_in == sbt_pkg::CH_NUL) begin
          // Unterminated string: report it, then end of input.
          two = 1'b1;
          first = '{kind: sbt_pkg::KIND_INVALID, cls: sbt_pkg::CLS_STRING,
                    ch: sbt_pkg::CH_NUL};
          second = '{kind: sbt_pkg::KIND_EOF, cls: sbt_pkg::CLS_NONE,
                     ch: sbt_pkg::CH_NUL};
          mode_nxt = sbt_pkg::MODE_IDLE;
        end else begin
          first = '{kind: sbt_pkg::KIND_CONTENT, cls: sbt_pkg::CLS_STRING, ch: byte_in};
        end
      end
      sbt_pkg::MODE_NUMBER, sbt_pkg::MODE_KEYWORD, sbt_pkg::MODE_SYMBOL: begin
        if (mode_r == sbt_pkg::MODE_NUMBER) begin
          run_cls = sbt_pkg::CLS_NUMBER;
          more = is_digit(byte_in) || (byte_in == sbt_pkg::CH_DOT);
        end else if (mode_r == sbt_pkg::MODE_KEYWORD) begin
          run_cls = sbt_pkg::CLS_KEYWORD;
          more = is_digit(byte_in) || is_alpha(byte_in) ||
                 (byte_in == sbt_pkg::CH_UNDER) || (byte_in == sbt_pkg::CH_DASH);
        end else begin
          run_cls = sbt_pkg::CLS_SYMBOL;
          more = is_digit(byte_in) || is_alpha(byte_in);
        end
        emit = 1'b1;
        if (more) begin
          first = '{kind: sbt_pkg::KIND_CONTENT, cls: run_cls, ch: byte_in};
        end else begin
          // Close the token, then lex the byte from idle.
          first = '{kind: sbt_pkg::KIND_END, cls: run_cls, ch: byte_in};
          two = idle.emit;
          second = idle.res;
          mode_nxt = idle.mode;
          if (idle.set_quote) quote_single_nxt = idle.quote_single;
          if (idle.line_inc && (line_r != '1)) line_nxt = line_r + 1'b1;
        end
      end
      default: begin
        emit = idle.emit;
        first = idle.res;
        mode_nxt = idle.mode;
        if (idle.set_quote) quote_single_nxt = idle.quote_single;
        if (idle.line_inc && (line_r != '1)) line_nxt = line_r + 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sbt_pkg::MODE_IDLE;
      quote_single_r <= 1'b0;
      line_r <= sbt_pkg::LINE_BITS'(1);
    end else if (accept) begin
      mode_r <= mode_nxt;
      quote_single_r <= quote_single_nxt;
      line_r <= line_nxt;
    end
  end

  assign push = accept && emit;
  assign push_data = '{two: two, first: first, second: second,
                       line: sbt_pkg::LINE_OUT_W'(line_r)};

endmodule

// File: rtl/sbt_queue.sv
`timescale 1ns / 1ps
module sbt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  sbt_pkg::q_ctl_t   ctl,
  input  sbt_pkg::tok_run_t wr_data,
  output sbt_pkg::tok_run_t head,
  output sbt_pkg::q_stat_t  stat
);

  sbt_pkg::tok_run_t                entries_r [sbt_pkg::QUEUE_DEPTH];
  logic [sbt_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [sbt_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                             do_push, do_pop;

  assign stat.full  = (count_r == sbt_pkg::QCNT_W'(sbt_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push = ctl.push && !stat.full;
  assign do_pop  = ctl.pop && !stat.empty;
  assign head = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_ptr_r] <= wr_data;
  end

endmodule

// File: rtl/sbt_back.sv
`timescale 1ns / 1ps
module sbt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sbt_pkg::tok_run_t head,
  input  logic              q_empty,
  output logic              pop,
  sbt_out_if.source         out_ch
);

  logic                            out_valid_r;
  sbt_pkg::res_t                   res_r;
  logic [sbt_pkg::LINE_OUT_W-1:0]  line_r;
  logic                            last_r;
  logic                            idx_r;
  logic                            load;
  logic                            last;
  sbt_pkg::res_t                   sel;

  assign load = !out_valid_r || out_ch.ready;
  assign last = !head.two || idx_r;
  assign sel  = idx_r ? head.second : head.first;
  assign pop  = load && !q_empty && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) idx_r <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      res_r <= sel;
      line_r <= head.line;
      last_r <= last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = res_r.kind;
  assign out_ch.token_class = res_r.cls;
  assign out_ch.char_out    = res_r.ch;
  assign out_ch.line_number = line_r;
  assign out_ch.last_of_run = last_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned BYTE_GOAL    = 950;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned SHOW_MAX     = 10;

  // One expected or observed token beat.
  typedef struct packed {
    logic [2:0]                     kind;
    logic [2:0]                     cls;
    logic [7:0]                     ch;
    logic [sbt_pkg::LINE_OUT_W-1:0] line;
    logic                           last;
  } tok_beat_t;

  // Lexer model plus the queue of token beats it has predicted.
  class tok_scoreboard;
    sbt_pkg::lex_mode_t            mode;
    logic                          single_quote;
    logic [sbt_pkg::LINE_BITS-1:0] line_cnt;
    tok_beat_t                     tok_q[$];
    int unsigned                   fails;

    function new();
      mode         = sbt_pkg::MODE_IDLE;
      single_quote = 1'b0;
      line_cnt     = sbt_pkg::LINE_BITS'(1);
      fails        = 0;
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_alnum(logic [7:0] b);
      return is_digit(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function void add_beat(logic [2:0] kind, logic [2:0] cls, logic [7:0] ch);
      tok_beat_t r;
      r.kind = kind;
      r.cls  = cls;
      r.ch   = ch;
      r.line = sbt_pkg::LINE_OUT_W'(line_cnt);
      r.last = 1'b0;
      tok_q.insert(tok_q.size(), r);
    endfunction

    // Lex a byte as the start of something new.
    function void lex_fresh(logic [7:0] b);
      mode = sbt_pkg::MODE_IDLE;
      case (b) inside
        sbt_pkg::CH_NUL: add_beat(sbt_pkg::KIND_EOF, sbt_pkg::CLS_NONE, sbt_pkg::CH_NUL);
        sbt_pkg::CH_LF, sbt_pkg::CH_CR: begin
          if (line_cnt != '1) line_cnt++;
        end
        sbt_pkg::CH_SPACE, sbt_pkg::CH_TAB, sbt_pkg::CH_FF, sbt_pkg::CH_VT: ;
        sbt_pkg::CH_SEMI: mode = sbt_pkg::MODE_COMMENT;
        sbt_pkg::CH_LPAREN: add_beat(sbt_pkg::KIND_OPEN, sbt_pkg::CLS_NONE, b);
        sbt_pkg::CH_RPAREN: add_beat(sbt_pkg::KIND_CLOSE, sbt_pkg::CLS_NONE, b);
        sbt_pkg::CH_DQUOTE, sbt_pkg::CH_SQUOTE: begin
          mode         = sbt_pkg::MODE_STRING;
          single_quote = (b == sbt_pkg::CH_SQUOTE);
        end
        sbt_pkg::CH_COLON: mode = sbt_pkg::MODE_KEYWORD;
        default: begin
          if (is_digit(b)) begin
            mode = sbt_pkg::MODE_NUMBER;
            add_beat(sbt_pkg::KIND_CONTENT, sbt_pkg::CLS_NUMBER, b);
          end else if (is_alnum(b)) begin
            mode = sbt_pkg::MODE_SYMBOL;
            add_beat(sbt_pkg::KIND_CONTENT, sbt_pkg::CLS_SYMBOL, b);
          end else begin
            add_beat(sbt_pkg::KIND_INVALID, sbt_pkg::CLS_NONE, b);
          end
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned n_prior;
      logic [2:0]  cls;
      logic        more;
      n_prior = tok_q.size();
      case (mode) inside
        sbt_pkg::MODE_COMMENT: begin
          if (b == sbt_pkg::CH_NUL || b == sbt_pkg::CH_LF || b == sbt_pkg::CH_CR)
            lex_fresh(b);
        end
        sbt_pkg::MODE_STRING: begin
          if (b == (single_quote ? sbt_pkg::CH_SQUOTE : sbt_pkg::CH_DQUOTE)) begin
            add_beat(sbt_pkg::KIND_END, sbt_pkg::CLS_STRING, b);
            mode = sbt_pkg::MODE_IDLE;
          end else if (b == sbt_pkg::CH_NUL) begin
            // unterminated string: report it, then end of input
            add_beat(sbt_pkg::KIND_INVALID, sbt_pkg::CLS_STRING, sbt_pkg::CH_NUL);
            add_beat(sbt_pkg::KIND_EOF, sbt_pkg::CLS_NONE, sbt_pkg::CH_NUL);
            mode = sbt_pkg::MODE_IDLE;
          end else begin
            add_beat(sbt_pkg::KIND_CONTENT, sbt_pkg::CLS_STRING, b);
          end
        end
        sbt_pkg::MODE_NUMBER, sbt_pkg::MODE_KEYWORD, sbt_pkg::MODE_SYMBOL: begin
          if (mode == sbt_pkg::MODE_NUMBER) begin
            cls  = sbt_pkg::CLS_NUMBER;
            more = is_digit(b) || b == sbt_pkg::CH_DOT;
          end else if (mode == sbt_pkg::MODE_KEYWORD) begin
            cls  = sbt_pkg::CLS_KEYWORD;
            more = is_alnum(b) || b == sbt_pkg::CH_UNDER || b == sbt_pkg::CH_DASH;
          end else begin
            cls  = sbt_pkg::CLS_SYMBOL;
            more = is_alnum(b);
          end
          if (more) begin
            add_beat(sbt_pkg::KIND_CONTENT, cls, b);
          end else begin
            // close the pending token, then lex the byte itself
            add_beat(sbt_pkg::KIND_END, cls, b);
            lex_fresh(b);
          end
        end
        default: lex_fresh(b);
      endcase
      if (tok_q.size() > n_prior) tok_q[tok_q.size() - 1].last = 1'b1;
    endfunction

    function void check_beat(tok_beat_t got);
      tok_beat_t want;
      if (tok_q.size() == 0) begin
        fails++;
        if (fails <= SHOW_MAX)
          $display("%0t unexpected beat: kind=%0d cls=%0d ch=%02h line=%0d last=%0b",
                   $realtime, got.kind, got.cls, got.ch, got.line, got.last);
        return;
      end
      want = tok_q.pop_front();
      if (got.kind !== want.kind || got.cls !== want.cls || got.ch !== want.ch ||
          got.line !== want.line || got.last !== want.last) begin
        fails++;
        if (fails <= SHOW_MAX)
          $display({"%0t beat mismatch: exp kind=%0d cls=%0d ch=%02h line=%0d last=%0b",
                    " / got kind=%0d cls=%0d ch=%02h line=%0d last=%0b"},
                   $realtime, want.kind, want.cls, want.ch, want.line, want.last,
                   got.kind, got.cls, got.ch, got.line, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sbt_in_if  in_ch ();
  sbt_out_if out_ch ();

  sexpr_byte_tokenizer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tok_scoreboard sb = new();

  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned bytes_sent;
  int unsigned bytes_taken = 0;
  int unsigned cycles = 0;
  int unsigned hold_left;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Feed the model with every accepted source byte.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_byte(in_ch.source_byte);
      bytes_taken <= bytes_taken + 1;
    end
  end

  // Check every token beat taken off the output.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_beat({out_ch.kind, out_ch.token_class, out_ch.char_out,
                     out_ch.line_number, out_ch.last_of_run});
  end

  // Count out one long receiver hold so the queue fills up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver: random back-pressure, held low through the long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Offer one byte and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.source_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_alpha();
    logic [7:0] c;
    c = 8'($urandom_range(25));
    return ($urandom_range(1) != 0) ? "a" + c : "A" + c;
  endfunction

  function automatic logic [7:0] rand_digit();
    logic [7:0] c;
    c = 8'($urandom_range(9));
    return "0" + c;
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(9) < 3) ? rand_digit() : rand_alpha();
  endfunction

  // Mostly well-formed tokens with random content; some noise and bare ends.
  task automatic send_token();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  quote;
    logic [7:0]  c;
    pick = $urandom_range(99);
    len  = $urandom_range(6);
    if (pick < 18) begin
      send_byte(rand_alpha());
      repeat (len) send_byte(rand_alnum());
    end else if (pick < 32) begin
      send_byte(rand_digit());
      repeat (len) send_byte(($urandom_range(4) == 0) ? sbt_pkg::CH_DOT : rand_digit());
    end else if (pick < 44) begin
      send_byte(sbt_pkg::CH_COLON);
      repeat (len) begin
        case ($urandom_range(5))
          0:       send_byte(sbt_pkg::CH_UNDER);
          1:       send_byte(sbt_pkg::CH_DASH);
          default: send_byte(rand_alnum());
        endcase
      end
    end else if (pick < 56) begin
      quote = ($urandom_range(1) != 0) ? sbt_pkg::CH_SQUOTE : sbt_pkg::CH_DQUOTE;
      send_byte(quote);
      repeat (len) begin
        c = ($urandom_range(5) == 0) ? 8'($urandom_range(255, 1)) : 8'($urandom_range(126, 32));
        if (c == quote) c = sbt_pkg::CH_LF;
        send_byte(c);
      end
      // leave a few strings open so a later end of input hits them
      if ($urandom_range(19) != 0) send_byte(quote);
    end else if (pick < 70) begin
      send_byte(($urandom_range(1) != 0) ? sbt_pkg::CH_LPAREN : sbt_pkg::CH_RPAREN);
    end else if (pick < 82) begin
      case ($urandom_range(5))
        0: send_byte(sbt_pkg::CH_SPACE);
        1: send_byte(sbt_pkg::CH_TAB);
        2: send_byte(sbt_pkg::CH_FF);
        3: send_byte(sbt_pkg::CH_VT);
        4: send_byte(sbt_pkg::CH_LF);
        default: send_byte(sbt_pkg::CH_CR);
      endcase
    end else if (pick < 87) begin
      send_byte(sbt_pkg::CH_SEMI);
      repeat (len) begin
        c = 8'($urandom_range(255, 1));
        if (c == sbt_pkg::CH_LF || c == sbt_pkg::CH_CR) c = sbt_pkg::CH_SPACE;
        send_byte(c);
      end
      send_byte(($urandom_range(2) == 0) ? sbt_pkg::CH_CR : sbt_pkg::CH_LF);
    end else if (pick < 97) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(sbt_pkg::CH_NUL);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.source_byte = sbt_pkg::CH_NUL;
    in_idle_pct       = 12;
    out_idle_pct      = 50;
    bytes_sent        = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: symbol closed by a paren, keyword closed by a colon, empty
    // keyword, number with a dot, newline inside a string, unterminated
    // string, comment closed by CR, illegal bytes, whitespace, end of input.
    send_text("(aZ9)");
    send_text(":k_-:(");
    send_text("1.\n");
    send_text("\"'\n\"");
    send_byte(sbt_pkg::CH_SQUOTE);
    send_byte(sbt_pkg::CH_NUL);
    send_text(";c\r");
    send_byte(sbt_pkg::CH_UNDER);
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(sbt_pkg::CH_TAB);
    send_byte(sbt_pkg::CH_FF);
    send_byte(sbt_pkg::CH_VT);
    send_byte(sbt_pkg::CH_SPACE);
    send_byte(sbt_pkg::CH_DOT);
    send_byte(sbt_pkg::CH_NUL);

    while (bytes_sent < BYTE_GOAL / 3) send_token();
    in_idle_pct  = 50;
    out_idle_pct = 12;
    while (bytes_sent < 2 * BYTE_GOAL / 3) send_token();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (bytes_sent < BYTE_GOAL) send_token();
    in_ch.valid <= 1'b0;
    @(posedge clk);

    // Drain, then give the pipeline time to show any stray beat.
    while (sb.tok_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fails == 0 && sb.tok_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: sexpr_byte_tokenizer_core.f
rtl/sbt_pkg.sv
rtl/sbt_in_if.sv
rtl/sbt_out_if.sv
rtl/sbt_front.sv
rtl/sbt_queue.sv
rtl/sbt_back.sv
rtl/sexpr_byte_tokenizer_core.sv
tb/tb_top.sv
